### hw/rtl/ptpp_pkg.sv
// shared types and constants for the packed triplet pixel plotter
`timescale 1ns / 1ps

package ptpp_pkg;

  localparam int DISPLAY_ROWS  = 160;
  localparam int DISPLAY_WIDTH = 160;
  localparam int WORDS_PER_ROW = (DISPLAY_WIDTH + 1) / 3 + 1;
  localparam int WORD_COUNT    = DISPLAY_ROWS * WORDS_PER_ROW;
  localparam int ADDR_W        = $clog2(WORD_COUNT);

  localparam logic [6:0]  COLUMN_BASE = 7'd37;
  localparam logic [15:0] FIELD_POS0  = 16'hF800;
  localparam logic [15:0] FIELD_POS1  = 16'h07E0;
  localparam logic [15:0] FIELD_POS2  = 16'h001F;

  // x / 3 for 8-bit x as (x * 171) >> 9
  localparam logic [7:0] DIV3_MUL   = 8'd171;
  localparam int         DIV3_SHIFT = 9;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_ADDR,
    ST_READ,
    ST_WRITE
  } ptpp_state_t;

  typedef struct packed {
    logic load;
    logic div;
    logic addr;
    logic rd;
    logic commit;
    logic clr;
  } ptpp_cmd_t;

  typedef struct packed {
    logic clr_last;
  } ptpp_status_t;

endpackage

### hw/rtl/packed_triplet_pixel_plotter.sv
// top level of the packed triplet pixel plotter
//
// input: present in_pixel_x, in_pixel_y and in_color with start; the word is
// taken at a rising edge where start is high and busy is low.
// config: cfg_we with cfg_wdata writes the mirror bit; write it while idle.
// output: out_valid is high for one cycle with row, column, the new
// three-pixel word and out_in_range; the receiver cannot stall.
// sequence: after the accepting edge the sequencer divides x by three, forms
// the address, reads then writes the display memory; out_valid rises after
// the write state, and no new word is taken until the sequencer is idle again.
// out-of-range draws take the same time, leave memory alone and report
// zeros with out_in_range low.
// reset: rst_n low clears the mirror bit and the sequencer; afterwards a
// clearing pass writes zero to all 8640 display words, one per cycle, with
// busy high throughout the pass.
`timescale 1ns / 1ps

module packed_triplet_pixel_plotter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  in_pixel_x,
  input  logic [7:0]  in_pixel_y,
  input  logic [15:0] in_color,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  output logic        out_valid,
  output logic [7:0]  out_row_address,
  output logic [6:0]  out_column_address,
  output logic [15:0] out_written_word,
  output logic        out_in_range
);
  import ptpp_pkg::*;

  ptpp_cmd_t    cmd;
  ptpp_status_t status;

  ptpp_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  ptpp_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_pixel_x         (in_pixel_x),
    .in_pixel_y         (in_pixel_y),
    .in_color           (in_color),
    .out_valid          (out_valid),
    .out_row_address    (out_row_address),
    .out_column_address (out_column_address),
    .out_written_word   (out_written_word),
    .out_in_range       (out_in_range)
  );

endmodule

### hw/rtl/ptpp_ctrl.sv
// sequencer for memory clear and per-word read-modify-write
`timescale 1ns / 1ps

module ptpp_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  ptpp_pkg::ptpp_status_t status,
  output ptpp_pkg::ptpp_cmd_t    cmd,
  output logic                  busy
);
  import ptpp_pkg::*;

  ptpp_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (status.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div   = 1'b1;
        state_nxt = ST_ADDR;
      end
      ST_ADDR: begin
        cmd.addr  = 1'b1;
        state_nxt = ST_READ;
      end
      ST_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_WRITE;
      end
      ST_WRITE: begin
        cmd.commit = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### hw/rtl/ptpp_datapath.sv
// address math, display memory and result registers
`timescale 1ns / 1ps

module ptpp_datapath (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ptpp_pkg::ptpp_cmd_t    cmd,
  output ptpp_pkg::ptpp_status_t status,
  input  logic                   cfg_we,
  input  logic                   cfg_wdata,
  input  logic [7:0]             in_pixel_x,
  input  logic [7:0]             in_pixel_y,
  input  logic [15:0]            in_color,
  output logic                   out_valid,
  output logic [7:0]             out_row_address,
  output logic [6:0]             out_column_address,
  output logic [15:0]            out_written_word,
  output logic                   out_in_range
);
  import ptpp_pkg::*;

  logic              mirror_r;
  logic [7:0]        x_r;
  logic [7:0]        y_r;
  logic              set_r;
  logic              range_r;
  logic [6:0]        quot_r;
  logic [6:0]        ofs_r;
  logic [15:0]       mask_r;
  logic [ADDR_W-1:0] index_r;
  logic [ADDR_W-1:0] clr_cnt_r;
  logic [15:0]       rdata_r;
  logic [15:0]       mem_q [WORD_COUNT];

  logic              valid_r;
  logic [7:0]        row_r;
  logic [6:0]        col_r;
  logic [15:0]       word_r;
  logic              inr_r;

  logic [15:0]       prod;
  logic [7:0]        triple;
  logic [1:0]        rem;
  logic [1:0]        pos;
  logic [6:0]        ofs;
  logic [15:0]       mask;
  logic [ADDR_W:0]   row_base;
  logic [ADDR_W:0]   idx_sum;
  logic [ADDR_W-1:0] index;
  logic [15:0]       new_word;
  logic              mem_we;
  logic [ADDR_W-1:0] waddr;
  logic [15:0]       wdata;

  function automatic logic [15:0] in_x_mul(input logic [7:0] v);
    in_x_mul = 16'(v) * 16'(DIV3_MUL);
  endfunction

  // divide by three
  assign prod = 16'(in_x_mul(x_r));

  always_comb begin
    triple = {quot_r, 1'b0} + {1'b0, quot_r};
    rem    = 2'(x_r - triple);
    if (mirror_r) begin
      ofs = quot_r + 7'(rem != 2'd0);
      case (rem)
        2'd1:    pos = 2'd2;
        2'd2:    pos = 2'd1;
        default: pos = rem;
      endcase
    end else begin
      ofs = quot_r;
      pos = rem;
    end
    case (pos)
      2'd0:    mask = FIELD_POS0;
      2'd1:    mask = FIELD_POS1;
      default: mask = FIELD_POS2;
    endcase
    row_base = (ADDR_W + 1)'(y_r) * (ADDR_W + 1)'(WORDS_PER_ROW);
    idx_sum  = row_base + (ADDR_W + 1)'(ofs);
    if (idx_sum >= (ADDR_W + 1)'(WORD_COUNT)) begin
      index = ADDR_W'(WORD_COUNT - 1);
    end else begin
      index = idx_sum[ADDR_W-1:0];
    end
  end

  assign new_word = set_r ? (rdata_r | mask_r) : (rdata_r & ~mask_r);
  assign mem_we   = cmd.clr || (cmd.commit && range_r);
  assign waddr    = cmd.clr ? clr_cnt_r : index_r;
  assign wdata    = cmd.clr ? 16'h0000 : new_word;

  assign status.clr_last = (clr_cnt_r == ADDR_W'(WORD_COUNT - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mirror_r  <= 1'b0;
      clr_cnt_r <= '0;
      valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        mirror_r <= cfg_wdata;
      end
      if (cmd.clr) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      valid_r <= cmd.commit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r     <= in_pixel_x;
      y_r     <= in_pixel_y;
      set_r   <= (in_color != 16'h0000);
      range_r <= (9'(in_pixel_x) < 9'(DISPLAY_WIDTH)) &&
                 (9'(in_pixel_y) < 9'(DISPLAY_ROWS));
    end
    if (cmd.div) begin
      quot_r <= prod[DIV3_SHIFT +: 7];
    end
    if (cmd.addr) begin
      ofs_r   <= ofs;
      mask_r  <= mask;
      index_r <= index;
    end
    if (cmd.commit) begin
      if (range_r) begin
        row_r  <= y_r;
        col_r  <= COLUMN_BASE + ofs_r;
        word_r <= new_word;
        inr_r  <= 1'b1;
      end else begin
        row_r  <= '0;
        col_r  <= '0;
        word_r <= '0;
        inr_r  <= 1'b0;
      end
    end
  end

  // display memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_q[waddr] <= wdata;
    end
    if (cmd.rd) begin
      rdata_r <= mem_q[index_r];
    end
  end

  assign out_valid          = valid_r;
  assign out_row_address    = row_r;
  assign out_column_address = col_r;
  assign out_written_word   = word_r;
  assign out_in_range       = inr_r;

endmodule

### hw/rtl/ptpp_checker.sv
// port-level checks for the packed triplet pixel plotter
`timescale 1ns / 1ps

module ptpp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [7:0]  out_row_address,
  input logic [6:0]  out_column_address,
  input logic [15:0] out_written_word,
  input logic        out_in_range
);

  // an accepted word always gets its result strobe
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##5 out_valid)
    else $error("result missing five cycles after accept");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

  a_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_ignored: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_in_range) |->
      (out_row_address == 8'd0 && out_column_address == 7'd0 &&
       out_written_word == 16'd0))
    else $error("ignored draw reports nonzero fields");

  a_column: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_in_range) |-> (out_column_address >= 7'd37))
    else $error("column below base");

endmodule

bind packed_triplet_pixel_plotter ptpp_checker u_ptpp_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .start              (start),
  .busy               (busy),
  .out_valid          (out_valid),
  .out_row_address    (out_row_address),
  .out_column_address (out_column_address),
  .out_written_word   (out_written_word),
  .out_in_range       (out_in_range)
);
